// ----- rtl/arlc_pkg.sv -----
// Shared types, character codes and pattern tables for the AT response line classifier.
package arlc_pkg;

	localparam int WIN_DEPTH   = 9;
	localparam int MAX_PAT_LEN = WIN_DEPTH + 1;
	localparam int NUM_PAT     = 9;
	localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
	localparam int PAT_W       = 8 * MAX_PAT_LEN;

	localparam logic [7:0] CHR_NUL    = 8'h00;
	localparam logic [7:0] CHR_LF     = 8'h0A;
	localparam logic [7:0] CHR_CR     = 8'h0D;
	localparam logic [7:0] CHR_PROMPT = 8'h3E;

	typedef enum logic [2:0] {
		RSP_NONE        = 3'd0,
		RSP_OK          = 3'd1,
		RSP_ERROR       = 3'd2,
		RSP_SMS_SENT    = 3'd3,
		RSP_NEW_SMS     = 3'd4,
		RSP_RING        = 3'd5,
		RSP_MODEM_RESET = 3'd6,
		RSP_PROMPT      = 3'd7
	} rsp_code_t;

	typedef logic [WIN_DEPTH-1:0][7:0] win_t;
	typedef logic [NUM_PAT-1:0]        seen_t;

	typedef struct packed {
		logic      has_result;
		rsp_code_t code;
		logic      hangup;
	} line_rsp_t;

	// Text is right-aligned: the last character sits in bits [7:0].
	localparam logic [PAT_W-1:0] PAT_TEXT [NUM_PAT] = '{
		PAT_W'("PBSTART"),
		PAT_W'("MODEM"),
		PAT_W'("SMS Ready"),
		PAT_W'("Call Ready"),
		PAT_W'("OK"),
		PAT_W'("ERROR"),
		PAT_W'("+CMGS"),
		PAT_W'("+CMTI"),
		PAT_W'("RING")
	};

	localparam logic [FILL_W-1:0] PAT_LEN [NUM_PAT] = '{
		4'd7, 4'd5, 4'd9, 4'd10, 4'd2, 4'd5, 4'd5, 4'd5, 4'd4
	};

	localparam rsp_code_t PAT_CODE [NUM_PAT] = '{
		RSP_MODEM_RESET, RSP_MODEM_RESET, RSP_MODEM_RESET, RSP_MODEM_RESET,
		RSP_OK, RSP_ERROR, RSP_SMS_SENT, RSP_NEW_SMS, RSP_RING
	};

endpackage

// ----- rtl/arlc_matcher.sv -----
// Parallel compare of the incoming byte plus window against every fixed pattern.
module arlc_matcher import arlc_pkg::*; (
	input  logic [7:0]        rx_byte,
	input  win_t              window,
	input  logic [FILL_W-1:0] fill,
	output seen_t             hits
);

	logic [MAX_PAT_LEN-1:0][7:0] tail;
	logic [FILL_W:0]             avail;

	always_comb begin
		tail[0] = rx_byte;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			tail[i+1] = window[i];
		end
		avail = {1'b0, fill} + 1'b1;
		for (int p = 0; p < NUM_PAT; p++) begin
			hits[p] = ({1'b0, PAT_LEN[p]} <= avail);
			for (int i = 0; i < MAX_PAT_LEN; i++) begin
				if ((FILL_W'(i) < PAT_LEN[p]) && (PAT_TEXT[p][8*i +: 8] != tail[i])) begin
					hits[p] = 1'b0;
				end
			end
		end
	end

endmodule

// ----- rtl/arlc_line_tracker.sv -----
// Per-line state: byte window, fill, length, pattern flags and end-of-line decision.
module arlc_line_tracker import arlc_pkg::*; #(
	parameter int LINE_WRAP = 99
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       step,
	output line_rsp_t  rsp
);

	localparam int LEN_W = $clog2(LINE_WRAP);

	win_t              win_q,  win_n;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic [LEN_W-1:0]  len_q,  len_n;
	seen_t             seen_q, seen_n;
	logic              zero_q, zero_n;

	seen_t             hits;
	logic [LEN_W:0]    len_inc;
	rsp_code_t         best;

	arlc_matcher u_matcher (
		.rx_byte (rx_byte),
		.window  (win_q),
		.fill    (fill_q),
		.hits    (hits)
	);

	always_comb begin
		// lowest index has highest priority
		best = RSP_NONE;
		for (int p = NUM_PAT - 1; p >= 0; p--) begin
			if (seen_q[p]) begin
				best = PAT_CODE[p];
			end
		end
	end

	always_comb begin
		len_inc = {1'b0, len_q} + 1'b1;
		win_n   = win_q;
		fill_n  = fill_q;
		len_n   = len_q;
		seen_n  = seen_q;
		zero_n  = zero_q;
		rsp     = '{has_result: 1'b0, code: RSP_NONE, hangup: 1'b0};
		if (rx_byte == CHR_PROMPT) begin
			rsp    = '{has_result: 1'b1, code: RSP_PROMPT, hangup: 1'b0};
			win_n  = '0;
			fill_n = '0;
			len_n  = '0;
			seen_n = '0;
			zero_n = 1'b0;
		end else if (rx_byte inside {CHR_CR, CHR_LF}) begin
			rsp.has_result = (len_q != '0);
			rsp.code       = best;
			rsp.hangup     = (best == RSP_RING);
			win_n  = '0;
			fill_n = '0;
			len_n  = '0;
			seen_n = '0;
			zero_n = 1'b0;
		end else begin
			zero_n = zero_q | (rx_byte == CHR_NUL);
			if (!zero_n) begin
				seen_n = seen_q | hits;
			end
			win_n = {win_q[WIN_DEPTH-2:0], rx_byte};
			if (fill_q != FILL_W'(WIN_DEPTH)) begin
				fill_n = fill_q + 1'b1;
			end
			len_n = len_inc[LEN_W-1:0];
			// wrap: drop everything and restart on the next fragment
			if (len_inc >= (LEN_W + 1)'(LINE_WRAP)) begin
				win_n  = '0;
				fill_n = '0;
				len_n  = '0;
				seen_n = '0;
				zero_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			fill_q <= '0;
			len_q  <= '0;
			seen_q <= '0;
			zero_q <= 1'b0;
		end else if (step) begin
			win_q  <= win_n;
			fill_q <= fill_n;
			len_q  <= len_n;
			seen_q <= seen_n;
			zero_q <= zero_n;
		end
	end

endmodule

// ----- rtl/at_response_line_classifier.sv -----
// Top level: input register, line tracker and result register of the response classifier.
// The input register holds each accepted byte, and its result is registered in the result register.
// Throughput: one byte per cycle; the line state in the tracker updates once per byte.
// A byte waits in the input register only while a result is held by out_stall.
// Reset (arst_n low) clears the line state, the input valid and the result valid.
module at_response_line_classifier import arlc_pkg::*; #(
	parameter int LINE_WRAP = 99
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] response_code,
	output logic       hangup_request
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire_s1;
	logic       accept;
	line_rsp_t  rsp;

	logic       out_valid_q;
	rsp_code_t  code_q;
	logic       hangup_q;

	arlc_line_tracker #(
		.LINE_WRAP (LINE_WRAP)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (byte_s1),
		.step    (fire_s1),
		.rsp     (rsp)
	);

	// a byte that makes no result never waits on the output side
	assign fire_s1  = valid_s1 && (!rsp.has_result || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire_s1;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && rsp.has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && rsp.has_result) begin
			code_q   <= rsp.code;
			hangup_q <= rsp.hangup;
		end
	end

	assign out_valid      = out_valid_q;
	assign response_code  = code_q;
	assign hangup_request = hangup_q;

endmodule

// ----- rtl/arlc_checker.sv -----
// Port-level assertions for the response classifier, bound to the top level.
module arlc_checker import arlc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] response_code,
	input logic       hangup_request
);

	// hang-up is only ever raised together with a ring result
	a_hangup_ring: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hangup_request |-> response_code == RSP_RING)
	else $error("hangup_request without ring code");

	// input is held back only while a result is stuck at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
	else $error("in_stall without a stalled result");

	// a fresh result traces back to a request accepted through the input register
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
	else $error("result appeared without an accepted request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(response_code)
			&& $stable(hangup_request))
	else $error("stalled result changed");

	a_prompt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && response_code == RSP_PROMPT |-> !hangup_request)
	else $error("prompt result with hangup");

endmodule

bind at_response_line_classifier arlc_checker u_arlc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.response_code  (response_code),
	.hangup_request (hangup_request)
);

// ----- sim/at_response_line_classifier_test.sv -----
// Testbench for the AT response line classifier: random modem lines against a line-state predictor.
module at_response_line_classifier_test;
	import arlc_pkg::*;

	localparam int LINE_WRAP   = 99;
	localparam int NUM_BYTES   = 1650;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		rsp_code_t code;
		logic      hangup;
	} expected_rsp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] response_code;
	logic       hangup_request;

	logic [7:0]    pending_bytes[$];
	expected_rsp_t expected_responses[$];
	int            mismatch_count = 0;
	int            cycle_count = 0;

	// predictor copy of the line state
	logic [7:0]  hist [WIN_DEPTH];
	int unsigned hist_fill;
	int unsigned line_len;
	logic [NUM_PAT-1:0] seen_flags;
	bit          nul_seen;

	string rsp_pattern [NUM_PAT] = '{
		"PBSTART", "MODEM", "SMS Ready", "Call Ready",
		"OK", "ERROR", "+CMGS", "+CMTI", "RING"
	};
	rsp_code_t rsp_pattern_code [NUM_PAT] = '{
		RSP_MODEM_RESET, RSP_MODEM_RESET, RSP_MODEM_RESET, RSP_MODEM_RESET,
		RSP_OK, RSP_ERROR, RSP_SMS_SENT, RSP_NEW_SMS, RSP_RING
	};

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic [7:0]  stall_phase = 8'h00;

	at_response_line_classifier #(.LINE_WRAP(LINE_WRAP)) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.response_code  (response_code),
		.hangup_request (hangup_request)
	);

	always #4 clk = ~clk;

	task automatic clear_line_state();
		for (int i = 0; i < WIN_DEPTH; i++)
			hist[i] = 8'h00;
		hist_fill = 0;
		line_len = 0;
		seen_flags = '0;
		nul_seen = 1'b0;
	endtask

	task automatic classify_byte(input logic [7:0] b);
		logic [7:0] tail [WIN_DEPTH+1];
		int n;
		bit hit;
		rsp_code_t code;
		if (b == CHR_PROMPT) begin
			clear_line_state();
			expected_responses.push_back('{RSP_PROMPT, 1'b0});
		end else if (b == CHR_CR || b == CHR_LF) begin
			if (line_len != 0) begin
				code = RSP_NONE;
				for (int p = NUM_PAT - 1; p >= 0; p--)
					if (seen_flags[p])
						code = rsp_pattern_code[p];
				expected_responses.push_back('{code, code == RSP_RING});
			end
			clear_line_state();
		end else begin
			if (b == CHR_NUL)
				nul_seen = 1'b1;
			if (!nul_seen) begin
				tail[0] = b;
				for (int i = 0; i < WIN_DEPTH; i++)
					tail[i+1] = hist[i];
				// match ends on the incoming byte; window must hold the whole pattern
				for (int p = 0; p < NUM_PAT; p++) begin
					n = rsp_pattern[p].len();
					hit = (n <= hist_fill + 1);
					for (int i = 0; i < n && hit; i++)
						if (rsp_pattern[p][n-1-i] != tail[i])
							hit = 1'b0;
					if (hit)
						seen_flags[p] = 1'b1;
				end
			end
			for (int i = WIN_DEPTH - 1; i > 0; i--)
				hist[i] = hist[i-1];
			hist[0] = b;
			if (hist_fill < WIN_DEPTH)
				hist_fill++;
			line_len++;
			if (line_len >= LINE_WRAP)
				clear_line_state();
		end
	endtask

	function automatic logic [7:0] filler_char();
		logic [7:0] c;
		c = 8'($urandom_range(8'h20, 8'h7E));
		if (c == CHR_PROMPT)
			c = 8'h2E;
		return c;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_bytes.push_back(s[i]);
	endtask

	task automatic push_fillers(input int count);
		repeat (count) pending_bytes.push_back(filler_char());
	endtask

	task automatic push_pattern();
		string s;
		s = rsp_pattern[$urandom_range(0, NUM_PAT - 1)];
		// occasionally a truncated pattern that must not match
		if ($urandom_range(0, 9) == 0)
			s = s.substr(0, s.len() - 2);
		push_text(s);
	endtask

	task automatic add_random_line();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 62) begin
			push_fillers($urandom_range(0, 3));
			push_pattern();
			if ($urandom_range(0, 3) == 0)
				push_pattern();
			push_fillers($urandom_range(0, 4));
		end else if (kind < 68) begin
			// lines around the wrap length, some ending exactly at it
			if ($urandom_range(0, 2) == 0) begin
				push_fillers(LINE_WRAP);
			end else begin
				n = $urandom_range(LINE_WRAP - 9, LINE_WRAP + 3);
				push_fillers(n);
				push_pattern();
			end
		end else if (kind < 76) begin
			push_fillers($urandom_range(0, 2));
			if ($urandom_range(0, 1))
				push_pattern();
			pending_bytes.push_back(CHR_NUL);
			push_pattern();
		end else if (kind < 84) begin
			push_fillers($urandom_range(0, 3));
			if ($urandom_range(0, 1))
				push_pattern();
			pending_bytes.push_back(CHR_PROMPT);
			if ($urandom_range(0, 1))
				push_pattern();
		end else begin
			repeat ($urandom_range(1, 12)) pending_bytes.push_back(8'($urandom_range(0, 255)));
		end
		pending_bytes.push_back($urandom_range(0, 1) ? CHR_CR : CHR_LF);
		if ($urandom_range(0, 3) == 0)
			pending_bytes.push_back(CHR_LF);
	endtask

	// sender: bursts of requests separated by random gaps
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				in_valid <= 1'b1;
				rx_byte <= pending_bytes.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall mode follows the top two bits of stall_phase
	always @(posedge clk) begin
		stall_phase <= stall_phase + 8'd1;
		case (stall_phase[7:6])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= 1'($urandom_range(0, 1));
			2'd2: out_stall <= (stall_phase[2:0] < 3'd5);
			default: out_stall <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		expected_rsp_t exp_rsp;
		if (!arst_n) begin
			clear_line_state();
		end else begin
			if (in_valid && !in_stall)
				classify_byte(rx_byte);
			if (out_valid && !out_stall) begin
				if (expected_responses.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: code %0d hangup %0b",
							response_code, hangup_request);
				end else begin
					exp_rsp = expected_responses.pop_front();
					if (response_code !== exp_rsp.code ||
							hangup_request !== exp_rsp.hangup) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: code exp %0d got %0d, hangup exp %0b got %0b",
								exp_rsp.code, response_code, exp_rsp.hangup,
								hangup_request);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		clear_line_state();
		// directed lines
		push_text("OK");
		pending_bytes.push_back(CHR_CR);
		push_text("RING");
		pending_bytes.push_back(CHR_LF);
		pending_bytes.push_back(CHR_CR);
		pending_bytes.push_back(CHR_PROMPT);
		push_text("ER");
		pending_bytes.push_back(CHR_PROMPT);
		pending_bytes.push_back(CHR_LF);
		pending_bytes.push_back(CHR_NUL);
		push_text("OK");
		pending_bytes.push_back(CHR_CR);
		pending_bytes.push_back(8'hFF);
		pending_bytes.push_back(CHR_CR);
		while (pending_bytes.size() < NUM_BYTES)
			add_random_line();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() > 0 || in_valid || expected_responses.size() > 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (expected_responses.size() > 0) begin
			mismatch_count += expected_responses.size();
			$display("%0d expected results never arrived", expected_responses.size());
		end
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/arlc_pkg.sv
rtl/arlc_matcher.sv
rtl/arlc_line_tracker.sv
rtl/at_response_line_classifier.sv
rtl/arlc_checker.sv
sim/at_response_line_classifier_test.sv
